[rtl/core/qau_pkg.sv]
package qau_pkg;

	localparam int FRAC   = 24;
	localparam int RAD_W  = 66;
	localparam int ROOT_W = 33;
	localparam int REM_W  = 35;
	localparam int QUO_W  = 25;
	localparam int SQ_N   = ROOT_W;
	localparam int DIV_N  = QUO_W;

	localparam logic [2:0] FN_MUL  = 3'd0;
	localparam logic [2:0] FN_MULV = 3'd1;
	localparam logic [2:0] FN_CONJ = 3'd2;
	localparam logic [2:0] FN_ROT  = 3'd3;
	localparam logic [2:0] FN_NORM = 3'd4;
	localparam logic [2:0] FN_RECW = 3'd5;

	localparam logic [RAD_W-1:0] ONE_SQ = RAD_W'(1) << (2 * FRAC);

	// operand order of the sixteen Hamilton terms, four per component w,x,y,z
	localparam logic [1:0] HAM_P [16] = '{2'd0, 2'd1, 2'd2, 2'd3, 2'd1, 2'd0, 2'd2, 2'd3,
		2'd2, 2'd0, 2'd3, 2'd1, 2'd3, 2'd0, 2'd1, 2'd2};
	localparam logic [1:0] HAM_Q [16] = '{2'd0, 2'd1, 2'd2, 2'd3, 2'd0, 2'd1, 2'd3, 2'd2,
		2'd0, 2'd2, 2'd1, 2'd3, 2'd0, 2'd3, 2'd2, 2'd1};

	typedef logic signed [31:0] fx_t;

	typedef struct packed {
		fx_t w;
		fx_t x;
		fx_t y;
		fx_t z;
	} quat_t;

	typedef struct packed {
		logic [2:0] func;
		quat_t      res;
		quat_t      a;
	} side_t;

	function automatic fx_t comp(input quat_t q, input logic [1:0] i);
		fx_t r;
		case (i)
			2'd0: r = q.w;
			2'd1: r = q.x;
			2'd2: r = q.y;
			default: r = q.z;
		endcase
		return r;
	endfunction

	function automatic fx_t neg_sat(input fx_t v);
		return (v == 32'sh8000_0000) ? 32'sh7FFF_FFFF : -v;
	endfunction

	function automatic quat_t conj(input quat_t a);
		quat_t r;
		r.w = a.w;
		r.x = neg_sat(a.x);
		r.y = neg_sat(a.y);
		r.z = neg_sat(a.z);
		return r;
	endfunction

	function automatic logic [31:0] absu(input fx_t v);
		return v[31] ? 32'(-v) : 32'(v);
	endfunction

	function automatic logic signed [65:0] sx66(input logic signed [63:0] v);
		return {{2{v[63]}}, v};
	endfunction

	// round half up at the binary point, then saturate to 32 bits
	function automatic fx_t rnd_sat(input logic signed [65:0] s);
		logic signed [65:0] t;
		fx_t r;
		t = (s + 66'sd8388608) >>> FRAC;
		if (t > 66'sd2147483647)
			r = 32'sh7FFF_FFFF;
		else if (t < -66'sd2147483648)
			r = 32'sh8000_0000;
		else
			r = t[31:0];
		return r;
	endfunction

endpackage

[rtl/core/quaternion_arithmetic_unit_core.sv]
// Quaternion unit on signed Q8.24 values, fully pipelined.
// Issue: drive func and the a/b components and raise start; an item is taken
// at every rising edge with start high and busy low. busy is held low, so an
// item may be issued on every cycle.
// Result: done is high for one cycle with res_w..res_z, magnitude and
// zero_fault. Results leave in issue order, one per cycle at full rate.
// Its back end is the 33-stage square-root pipeline (one root bit per
// stage) followed by the 25-stage divider used by normalize; every operation
// goes through the same fixed-length pipeline.
// func: multiply, multiply by vector, conjugate, rotate vector,
// normalize, recover w; codes 6 and 7 give all-zero results.
// Reset clears all stage valid bits; items in flight are dropped.
// There is no back-pressure: the receiver must take each result when done
// is high.
module quaternion_arithmetic_unit_core import qau_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [2:0]  func,
	input  fx_t         a_w,
	input  fx_t         a_x,
	input  fx_t         a_y,
	input  fx_t         a_z,
	input  fx_t         b_w,
	input  fx_t         b_x,
	input  fx_t         b_y,
	input  fx_t         b_z,
	output logic        done,
	output fx_t         res_w,
	output fx_t         res_x,
	output fx_t         res_y,
	output fx_t         res_z,
	output logic [30:0] magnitude,
	output logic        zero_fault
);

	logic              v_s1, v_s2, v_s3, v_s4, v_s5;
	logic [2:0]        func_s1, func_s2, func_s3, func_s4, func_s5;
	quat_t             a_s1, a_s2, a_s3, a_s4, a_s5;
	quat_t             b_s1;
	quat_t             qa_in;
	quat_t             t_a, t_b;
	quat_t             c_s3;
	quat_t             res_s4, res_s5;
	logic [63:0]       sq_s2 [4];
	logic [RAD_W-1:0]  ssum_s3, rad_s4, rad_s5;
	side_t             sq_side, dv_side, fin_side;
	logic              dv_vld, fin_vld;
	logic [ROOT_W-1:0] dv_root, fin_root;
	logic [QUO_W-1:0]  quo [4];
	quat_t             fin_res;
	logic [30:0]       fin_mag;
	logic              fin_fault;

	assign busy = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			v_s1 <= start && !busy;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		func_s1 <= func;
		a_s1    <= '{w: a_w, x: a_x, y: a_y, z: a_z};
		b_s1    <= '{w: b_w, x: b_x, y: b_y, z: b_z};
		func_s2 <= func_s1;
		a_s2    <= a_s1;
		func_s3 <= func_s2;
		a_s3    <= a_s2;
		func_s4 <= func_s3;
		a_s4    <= a_s3;
		func_s5 <= func_s4;
		a_s5    <= a_s4;
	end

	always_comb begin
		qa_in = b_s1;
		if (func_s1 == FN_MULV || func_s1 == FN_ROT)
			qa_in.w = '0;
	end

	qau_ham u_ham_a (
		.clk (clk),
		.p   (a_s1),
		.q   (qa_in),
		.r   (t_a)
	);

	always_ff @(posedge clk) begin
		for (int i = 0; i < 4; i++)
			sq_s2[i] <= absu(comp(a_s1, 2'(i))) * absu(comp(a_s1, 2'(i)));
	end

	always_ff @(posedge clk) begin
		c_s3 <= conj(a_s2);
		if (func_s2 == FN_NORM)
			ssum_s3 <= RAD_W'(sq_s2[0]) + RAD_W'(sq_s2[1]) + RAD_W'(sq_s2[2])
				+ RAD_W'(sq_s2[3]);
		else
			ssum_s3 <= RAD_W'(sq_s2[1]) + RAD_W'(sq_s2[2]) + RAD_W'(sq_s2[3]);
	end

	// second product of the rotation: (a*v) * conj(a)
	qau_ham u_ham_b (
		.clk (clk),
		.p   (t_a),
		.q   (c_s3),
		.r   (t_b)
	);

	always_ff @(posedge clk) begin
		case (func_s3)
			FN_MUL, FN_MULV: res_s4 <= t_a;
			FN_CONJ:         res_s4 <= c_s3;
			FN_RECW:         res_s4 <= '{w: '0, x: a_s3.x, y: a_s3.y, z: a_s3.z};
			default:         res_s4 <= '0;
		endcase
		case (func_s3)
			FN_NORM: rad_s4 <= ssum_s3;
			FN_RECW: rad_s4 <= (ssum_s3 >= ONE_SQ) ? '0 : ONE_SQ - ssum_s3;
			default: rad_s4 <= '0;
		endcase
		res_s5 <= res_s4;
		rad_s5 <= rad_s4;
	end

	always_comb begin
		sq_side.func = func_s5;
		sq_side.a    = a_s5;
		sq_side.res  = res_s5;
		if (func_s5 == FN_ROT)
			sq_side.res = '{w: '0, x: t_b.x, y: t_b.y, z: t_b.z};
	end

	qau_sqrt u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_vld   (v_s5),
		.in_side  (sq_side),
		.rad      (rad_s5),
		.out_vld  (dv_vld),
		.out_side (dv_side),
		.root     (dv_root)
	);

	qau_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_vld   (dv_vld),
		.in_side  (dv_side),
		.in_root  (dv_root),
		.out_vld  (fin_vld),
		.out_side (fin_side),
		.out_root (fin_root),
		.quo      (quo)
	);

	always_comb begin
		fx_t qv [4];
		for (int i = 0; i < 4; i++) begin
			qv[i] = fx_t'({{(32-QUO_W){1'b0}}, quo[i]});
			if (comp(fin_side.a, 2'(i)) < 0)
				qv[i] = -qv[i];
		end
		fin_res   = fin_side.res;
		fin_mag   = '0;
		fin_fault = 1'b0;
		case (fin_side.func)
			FN_NORM: begin
				if (fin_root == '0) begin
					fin_res   = '0;
					fin_fault = 1'b1;
				end else begin
					fin_res = '{w: qv[0], x: qv[1], y: qv[2], z: qv[3]};
					fin_mag = (fin_root[ROOT_W-1] || fin_root[31]) ? '1 : fin_root[30:0];
				end
			end
			FN_RECW: fin_res.w = fx_t'(32'(ROOT_W'(0) - fin_root));
			default: fin_res = fin_side.res;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			done <= 1'b0;
		else
			done <= fin_vld;
	end

	always_ff @(posedge clk) begin
		res_w      <= fin_res.w;
		res_x      <= fin_res.x;
		res_y      <= fin_res.y;
		res_z      <= fin_res.z;
		magnitude  <= fin_mag;
		zero_fault <= fin_fault;
	end

`ifndef SYNTHESIS
	a_fault_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && zero_fault |-> magnitude == '0 && res_w == '0 && res_x == '0
			&& res_y == '0 && res_z == '0)
		else $error("fault item with non-zero payload");

	a_issue: assert property (@(posedge clk) disable iff (!arst_n)
		start |=> v_s1)
		else $error("issued item not captured");

	a_front_valid: assert property (@(posedge clk) disable iff (!arst_n)
		v_s5 |-> $past(v_s1, 4))
		else $error("front pipeline valid out of step");

	a_mag_fault: assert property (@(posedge clk) disable iff (!arst_n)
		done && magnitude != '0 |-> !zero_fault)
		else $error("magnitude with fault");
`endif

endmodule

[rtl/core/qau_ham.sv]
module qau_ham import qau_pkg::*; (
	input  logic  clk,
	input  quat_t p,
	input  quat_t q,
	output quat_t r
);

	fx_t pa [4];
	fx_t qa [4];
	logic signed [63:0] pr_s1 [16];
	fx_t rc [4];

	always_comb begin
		for (int i = 0; i < 4; i++) begin
			pa[i] = comp(p, 2'(i));
			qa[i] = comp(q, 2'(i));
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 16; i++)
			pr_s1[i] <= pa[HAM_P[i]] * qa[HAM_Q[i]];
	end

	// w: + - - -, x/y/z: + + + -
	always_comb begin
		logic signed [65:0] acc;
		for (int k = 0; k < 4; k++) begin
			acc = sx66(pr_s1[4*k]);
			for (int j = 1; j < 4; j++) begin
				if (k == 0 || j == 3)
					acc = acc - sx66(pr_s1[4*k+j]);
				else
					acc = acc + sx66(pr_s1[4*k+j]);
			end
			rc[k] = rnd_sat(acc);
		end
	end

	always_ff @(posedge clk) begin
		r.w <= rc[0];
		r.x <= rc[1];
		r.y <= rc[2];
		r.z <= rc[3];
	end

endmodule

[rtl/core/qau_sqrt.sv]
module qau_sqrt import qau_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_vld,
	input  side_t             in_side,
	input  logic [RAD_W-1:0]  rad,
	output logic              out_vld,
	output side_t             out_side,
	output logic [ROOT_W-1:0] root
);

	logic [SQ_N:0]       vld_s;
	side_t               side_s [SQ_N+1];
	logic [RAD_W-1:0]    rad_s  [SQ_N+1];
	logic [REM_W-1:0]    rem_s  [SQ_N+1];
	logic [ROOT_W-1:0]   root_s [SQ_N+1];

	assign vld_s[0]  = in_vld;
	assign side_s[0] = in_side;
	assign rad_s[0]  = rad;
	assign rem_s[0]  = '0;
	assign root_s[0] = '0;

	// one root bit per stage, two radicand bits consumed
	for (genvar k = 0; k < SQ_N; k++) begin : g_st
		logic [REM_W+1:0] sh;
		logic [REM_W+1:0] trial;
		logic             ge;

		assign sh    = {rem_s[k], rad_s[k][RAD_W-1 -: 2]};
		assign trial = {2'b00, root_s[k], 2'b01};
		assign ge    = sh >= trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				vld_s[k+1] <= 1'b0;
			else
				vld_s[k+1] <= vld_s[k];
		end

		always_ff @(posedge clk) begin
			side_s[k+1] <= side_s[k];
			rad_s[k+1]  <= {rad_s[k][RAD_W-3:0], 2'b00};
			rem_s[k+1]  <= ge ? REM_W'(sh - trial) : sh[REM_W-1:0];
			root_s[k+1] <= {root_s[k][ROOT_W-2:0], ge};
		end
	end

	assign out_vld  = vld_s[SQ_N];
	assign out_side = side_s[SQ_N];
	assign root     = root_s[SQ_N];

endmodule

[rtl/core/qau_div.sv]
module qau_div import qau_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_vld,
	input  side_t             in_side,
	input  logic [ROOT_W-1:0] in_root,
	output logic              out_vld,
	output side_t             out_side,
	output logic [ROOT_W-1:0] out_root,
	output logic [QUO_W-1:0]  quo [4]
);

	logic [DIV_N:0]     vld_s;
	side_t              side_s [DIV_N+1];
	logic [ROOT_W-1:0]  root_s [DIV_N+1];
	logic [ROOT_W-1:0]  rem_s  [4][DIV_N+1];
	logic [QUO_W-1:0]   nb_s   [4][DIV_N+1];
	logic [QUO_W-1:0]   quo_s  [4][DIV_N+1];

	assign vld_s[0]  = in_vld;
	assign side_s[0] = in_side;
	assign root_s[0] = in_root;

	for (genvar k = 0; k < DIV_N; k++) begin : g_st
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				vld_s[k+1] <= 1'b0;
			else
				vld_s[k+1] <= vld_s[k];
		end

		always_ff @(posedge clk) begin
			side_s[k+1] <= side_s[k];
			root_s[k+1] <= root_s[k];
		end
	end

	// |a| * 2^24 / root; the quotient stays below 2^25
	for (genvar l = 0; l < 4; l++) begin : g_lane
		logic [31:0] mag;

		assign mag         = absu(comp(in_side.a, 2'(l)));
		assign rem_s[l][0] = {2'b00, mag[31:1]};
		assign nb_s[l][0]  = {mag[0], {(QUO_W-1){1'b0}}};
		assign quo_s[l][0] = '0;

		for (genvar k = 0; k < DIV_N; k++) begin : g_st
			logic [ROOT_W:0] sh;
			logic            ge;

			assign sh = {rem_s[l][k], nb_s[l][k][QUO_W-1]};
			assign ge = sh >= {1'b0, root_s[k]};

			always_ff @(posedge clk) begin
				rem_s[l][k+1] <= ge ? ROOT_W'(sh - {1'b0, root_s[k]}) : sh[ROOT_W-1:0];
				nb_s[l][k+1]  <= {nb_s[l][k][QUO_W-2:0], 1'b0};
				quo_s[l][k+1] <= {quo_s[l][k][QUO_W-2:0], ge};
			end
		end

		assign quo[l] = quo_s[l][DIV_N];
	end

	assign out_vld  = vld_s[DIV_N];
	assign out_side = side_s[DIV_N];
	assign out_root = root_s[DIV_N];

endmodule
